// ===== hw/rtl/npcs_pkg.sv =====
// Shared types and constants for the nearest palette colour search block.
package npcs_pkg;

    // Default palette depth
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Field widths
    localparam int COLOR_W     = 8;
    localparam int INDEX_W     = 8;
    localparam int DIST_W      = 20;
    localparam int SQ_W        = 2 * COLOR_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int KEY_W       = 3 * COLOR_W;
    localparam int ENTRY_W     = 4 * COLOR_W;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_FIRST   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LAST    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ENABLE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_COLOR     = 3'd4;

    // Input transaction
    typedef struct packed {
        logic               cmd;
        logic [INDEX_W-1:0] entry_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } ncs_in_t;

    // Result transaction
    typedef struct packed {
        logic [INDEX_W-1:0] best_index;
        logic               key_hit;
        logic [DIST_W-1:0]  best_distance;
    } ncs_out_t;

    // One colour, as stored in the palette
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } ncs_rgba_t;

    // Tag travelling alongside an entry through the distance pipeline
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [INDEX_W-1:0] index;
    } ncs_tag_t;

endpackage

// ===== hw/rtl/npcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module npcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/npcs_dist.sv =====
// Two-stage squared-distance unit, one palette entry per cycle.
module npcs_dist (
    input  logic                          clk,
    input  logic                          rst_n,
    input  npcs_pkg::ncs_tag_t            tag_in,
    input  npcs_pkg::ncs_rgba_t           entry,
    input  npcs_pkg::ncs_rgba_t           pixel,
    input  logic                          weighted,
    output npcs_pkg::ncs_tag_t            tag_out,
    output logic [npcs_pkg::DIST_W-1:0]   entry_dist
);

    import npcs_pkg::*;

    logic [COLOR_W-1:0] dr, dg, db, da;
    logic [SQ_W-1:0]    sq_r_next, sq_g_next, sq_b_next, sq_a_next;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg, sq_a_reg;
    logic               weighted_reg;
    ncs_tag_t           tag_sq_reg, tag_sum_reg;
    logic [DIST_W-1:0]  dist_next, dist_reg;
    logic [DIST_W-1:0]  wr, wg;

    // Absolute differences and squares
    always_comb
    begin
        dr = (entry.red   > pixel.red)   ? entry.red   - pixel.red   : pixel.red   - entry.red;
        dg = (entry.green > pixel.green) ? entry.green - pixel.green : pixel.green - entry.green;
        db = (entry.blue  > pixel.blue)  ? entry.blue  - pixel.blue  : pixel.blue  - entry.blue;
        da = (entry.alpha > pixel.alpha) ? entry.alpha - pixel.alpha : pixel.alpha - entry.alpha;
        sq_r_next = SQ_W'(dr) * SQ_W'(dr);
        sq_g_next = SQ_W'(dg) * SQ_W'(dg);
        sq_b_next = SQ_W'(db) * SQ_W'(db);
        sq_a_next = SQ_W'(da) * SQ_W'(da);
    end

    // Distance sum: in weighted mode 3 red, 6 green as shift-and-add, else a plain sum
    always_comb
    begin
        if (weighted_reg)
        begin
            wr = (DIST_W'(sq_r_reg) << 1) + DIST_W'(sq_r_reg);
            wg = (DIST_W'(sq_g_reg) << 2) + (DIST_W'(sq_g_reg) << 1);
        end
        else
        begin
            wr = DIST_W'(sq_r_reg);
            wg = DIST_W'(sq_g_reg);
        end
        dist_next = wr + wg + DIST_W'(sq_b_reg) + DIST_W'(sq_a_reg);
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        sq_r_reg     <= sq_r_next;
        sq_g_reg     <= sq_g_next;
        sq_b_reg     <= sq_b_next;
        sq_a_reg     <= sq_a_next;
        weighted_reg <= weighted;
        dist_reg     <= dist_next;
    end

    // Tag stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_sq_reg  <= '0;
            tag_sum_reg <= '0;
        end
        else
        begin
            tag_sq_reg  <= tag_in;
            tag_sum_reg <= tag_sq_reg;
        end
    end

    assign tag_out    = tag_sum_reg;
    assign entry_dist = dist_reg;

endmodule

// ===== hw/rtl/nearest_palette_color_search.sv =====
// Nearest palette colour search: top level with sequencer and best-match tracking.
//
// A load transaction (cmd 0) writes one palette entry in the cycle it is
// accepted and gives no result; busy stays low. A match transaction (cmd 1)
// whose RGB equals an enabled key colour gives its result in the cycle after
// acceptance. Any other match scans entries range_first..range_last, one
// per cycle through the single palette read port and a pipelined distance
// unit, with busy high while the scan runs; if the range is inverted only
// range_first is scanned. Each result is shown for exactly one cycle with
// done high; the receiver cannot stall it. Configuration writes are always
// ready and must be issued only while the block is idle.
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  npcs_pkg::ncs_in_t                  item,
    output logic                               done,
    output npcs_pkg::ncs_out_t                 result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [npcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [npcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import npcs_pkg::*;

    localparam int                 IDX_W     = $clog2(PALETTE_ENTRIES);
    localparam logic [INDEX_W:0]   ENTRIES_X = (INDEX_W + 1)'(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0]   TOP_IDX   = IDX_W'(PALETTE_ENTRIES - 1);

    // Configuration registers
    logic               mode_reg;
    logic [INDEX_W-1:0] range_first_reg;
    logic [INDEX_W-1:0] range_last_reg;
    logic               key_enable_reg;
    logic [KEY_W-1:0]   key_color_reg;

    // Sequencer
    logic               busy_reg, busy_next;
    logic               issuing_reg, issuing_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]   stop_reg, stop_next;
    ncs_rgba_t          pixel_reg;

    // Best match tracking
    logic               have_best_reg, have_best_next;
    logic [INDEX_W-1:0] best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]  best_d_reg, best_d_next;
    logic               done_reg, done_next;
    ncs_out_t           result_reg, result_next;

    logic               accept, is_match, key_match, load_we;
    logic [IDX_W-1:0]   first_sat, last_sat;
    ncs_tag_t           tag_issue, tag_ram_reg, tag_out;
    ncs_rgba_t          entry_rd, pixel_in;
    logic [ENTRY_W-1:0] rd_data;
    logic [DIST_W-1:0]  entry_dist;
    logic               take;

    assign accept    = start && !busy_reg;
    assign is_match  = (item.cmd == CMD_MATCH);
    assign key_match = key_enable_reg && ({item.red, item.green, item.blue} == key_color_reg);
    assign load_we   = accept && (item.cmd == CMD_LOAD) && ({1'b0, item.entry_index} < ENTRIES_X);
    assign cfg_ready = 1'b1;

    // Range bounds saturate to the last palette entry
    always_comb
    begin
        first_sat = ({1'b0, range_first_reg} >= ENTRIES_X) ? TOP_IDX : range_first_reg[IDX_W-1:0];
        last_sat  = ({1'b0, range_last_reg}  >= ENTRIES_X) ? TOP_IDX : range_last_reg[IDX_W-1:0];
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            range_first_reg <= '0;
            range_last_reg  <= '1;
            key_enable_reg  <= 1'b0;
            key_color_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DISTANCE_MODE: mode_reg        <= cfg_data[0];
                REG_RANGE_FIRST:   range_first_reg <= cfg_data[INDEX_W-1:0];
                REG_RANGE_LAST:    range_last_reg  <= cfg_data[INDEX_W-1:0];
                REG_KEY_ENABLE:    key_enable_reg  <= cfg_data[0];
                REG_KEY_COLOR:     key_color_reg   <= cfg_data[KEY_W-1:0];
                default:           ;
            endcase
        end
    end

    // Palette store
    assign pixel_in = '{red: item.red, green: item.green, blue: item.blue, alpha: item.alpha};

    npcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (load_we),
        .wr_addr (item.entry_index[IDX_W-1:0]),
        .wr_data (pixel_in),
        .rd_en   (issuing_reg),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign entry_rd = rd_data;

    // Address issue tag, registered so that it lines up with the RAM read data
    always_comb
    begin
        tag_issue.valid = issuing_reg;
        tag_issue.last  = (addr_reg == stop_reg);
        tag_issue.index = INDEX_W'(addr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_ram_reg <= '0;
        end
        else
        begin
            tag_ram_reg <= tag_issue;
        end
    end

    // Latch the pixel of an accepted match
    always_ff @(posedge clk)
    begin
        if (accept && is_match)
        begin
            pixel_reg <= pixel_in;
        end
    end

    npcs_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag_in     (tag_ram_reg),
        .entry      (entry_rd),
        .pixel      (pixel_reg),
        .weighted   (mode_reg),
        .tag_out    (tag_out),
        .entry_dist (entry_dist)
    );

    // Sequencer and best-match update
    always_comb
    begin
        busy_next      = busy_reg;
        issuing_next   = issuing_reg;
        addr_next      = addr_reg;
        stop_next      = stop_reg;
        have_best_next = have_best_reg;
        best_idx_next  = best_idx_reg;
        best_d_next    = best_d_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        take           = 1'b0;

        // Start of a match
        if (accept && is_match)
        begin
            if (key_match)
            begin
                done_next   = 1'b1;
                result_next = '{best_index: '0, key_hit: 1'b1, best_distance: '0};
            end
            else
            begin
                busy_next      = 1'b1;
                issuing_next   = 1'b1;
                addr_next      = first_sat;
                stop_next      = (first_sat > last_sat) ? first_sat : last_sat;
                have_best_next = 1'b0;
            end
        end

        // Address stepping
        if (issuing_reg)
        begin
            if (addr_reg == stop_reg)
            begin
                issuing_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + IDX_W'(1);
            end
        end

        // Compare; strict less-than keeps the lowest index on ties
        if (tag_out.valid)
        begin
            take = !have_best_reg || (entry_dist < best_d_reg);
            if (take)
            begin
                best_idx_next = tag_out.index;
                best_d_next   = entry_dist;
            end
            have_best_next = 1'b1;
            if (tag_out.last)
            begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                result_next = '{best_index: best_idx_next, key_hit: 1'b0,
                                best_distance: best_d_next};
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            issuing_reg   <= 1'b0;
            have_best_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            issuing_reg   <= issuing_next;
            have_best_reg <= have_best_next;
            done_reg      <= done_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        stop_reg     <= stop_next;
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        result_reg   <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the nearest palette colour search block.
module tb_top;
    import npcs_pkg::*;

    localparam int NUM_ENTRIES = PALETTE_ENTRIES_DEF;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    ncs_in_t                item;
    logic                   done;
    ncs_out_t               result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the palette and the configuration registers
    ncs_rgba_t              palette_shadow [NUM_ENTRIES];
    logic                   mode_weighted;
    logic [INDEX_W-1:0]     scan_first;
    logic [INDEX_W-1:0]     scan_last;
    logic                   key_en;
    logic [KEY_W-1:0]       key_rgb;

    // Match results still owed by the block, oldest first
    ncs_out_t               pending_matches [$];
    int                     err_count;
    int                     send_idle_pct;

    nearest_palette_color_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Distance arithmetic
    function automatic int unsigned sq_diff(input logic [COLOR_W-1:0] a,
                                            input logic [COLOR_W-1:0] b);
        int d;
        d = int'(a) - int'(b);
        return int'(d * d);
    endfunction

    function automatic int unsigned colour_distance(input ncs_rgba_t e, input ncs_in_t px,
                                                    input logic weighted);
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        int unsigned da;
        dr = sq_diff(e.red, px.red);
        dg = sq_diff(e.green, px.green);
        db = sq_diff(e.blue, px.blue);
        da = sq_diff(e.alpha, px.alpha);
        if (weighted)
            return 3 * dr + 6 * dg + db + da;
        return dr + dg + db + da;
    endfunction

    // Expected answer for a match: key test first, then a lowest-index-wins scan
    function automatic ncs_out_t nearest_entry(input ncs_in_t px);
        ncs_out_t    r;
        int unsigned best_d;
        int unsigned d;
        int          best;
        if (key_en && {px.red, px.green, px.blue} == key_rgb)
        begin
            r.best_index    = '0;
            r.key_hit       = 1'b1;
            r.best_distance = '0;
            return r;
        end
        best   = int'(scan_first);
        best_d = colour_distance(palette_shadow[scan_first], px, mode_weighted);
        for (int i = int'(scan_first) + 1; i <= int'(scan_last); i++)
        begin
            d = colour_distance(palette_shadow[i[INDEX_W-1:0]], px, mode_weighted);
            if (d < best_d)
            begin
                best_d = d;
                best   = i;
            end
        end
        r.best_index    = best[INDEX_W-1:0];
        r.key_hit       = 1'b0;
        r.best_distance = best_d[DIST_W-1:0];
        return r;
    endfunction

    function automatic ncs_in_t make_item(input logic c, input logic [INDEX_W-1:0] idx,
                                          input logic [COLOR_W-1:0] r,
                                          input logic [COLOR_W-1:0] g,
                                          input logic [COLOR_W-1:0] b,
                                          input logic [COLOR_W-1:0] a);
        ncs_in_t it;
        it.cmd         = c;
        it.entry_index = idx;
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        it.alpha       = a;
        return it;
    endfunction

    // Random values at field width
    function automatic logic [COLOR_W-1:0] rnd_byte();
        return COLOR_W'($urandom_range(255, 0));
    endfunction

    function automatic logic [INDEX_W-1:0] rnd_index(input int hi, input int lo);
        return INDEX_W'($urandom_range(hi, lo));
    endfunction

    // One register write transaction; called at a falling edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DISTANCE_MODE: mode_weighted = data[0];
            REG_RANGE_FIRST:   scan_first    = data[INDEX_W-1:0];
            REG_RANGE_LAST:    scan_last     = data[INDEX_W-1:0];
            REG_KEY_ENABLE:    key_en        = data[0];
            REG_KEY_COLOR:     key_rgb       = data[KEY_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic mode, input logic [INDEX_W-1:0] f,
                              input logic [INDEX_W-1:0] l, input logic ken,
                              input logic [KEY_W-1:0] kcol);
        write_reg(REG_DISTANCE_MODE, CFG_DATA_W'(mode));
        write_reg(REG_RANGE_FIRST, CFG_DATA_W'(f));
        write_reg(REG_RANGE_LAST, CFG_DATA_W'(l));
        write_reg(REG_KEY_ENABLE, CFG_DATA_W'(ken));
        write_reg(REG_KEY_COLOR, kcol);
    endtask

    // Send one transaction; random idle gaps may drop start before it returns
    task automatic send_item(input ncs_in_t it);
        start = 1'b1;
        item  = it;
        do
            @(posedge clk);
        while (busy);
        if (it.cmd == CMD_LOAD)
            palette_shadow[it.entry_index] = {it.red, it.green, it.blue, it.alpha};
        else
            pending_matches.push_back(nearest_entry(it));
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
    endtask

    // Hold off until every owed result is in; loads leave no result, so pad a little
    task automatic wait_drained();
        start = 1'b0;
        while (pending_matches.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        ncs_out_t want;
        if (rst_n && done)
        begin
            if (pending_matches.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual index %0d key %0b dist %0d",
                         $time, result.best_index, result.key_hit, result.best_distance);
            end
            else
            begin
                want = pending_matches.pop_front();
                check_field("best_index", 32'(want.best_index), 32'(result.best_index));
                check_field("key_hit", 32'(want.key_hit), 32'(result.key_hit));
                check_field("best_distance", 32'(want.best_distance),
                            32'(result.best_distance));
            end
        end
    end

    // Every entry gets written before any scan; entry 0 black, entry 255 white
    task automatic test_palette_fill();
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (i == 0)
                send_item(make_item(CMD_LOAD, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
            else if (i == NUM_ENTRIES - 1)
                send_item(make_item(CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
            else
                send_item(make_item(CMD_LOAD, i[INDEX_W-1:0], rnd_byte(),
                                    rnd_byte(), rnd_byte(), rnd_byte()));
        end
    endtask

    // Whole palette in both distance modes
    task automatic test_full_range();
        wait_drained();
        set_config(1'b0, 8'd0, 8'd255, 1'b0, 24'h000000);
        send_item(make_item(CMD_MATCH, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_MATCH, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        wait_drained();
        set_config(1'b1, 8'd0, 8'd255, 1'b0, 24'h000000);
        send_item(make_item(CMD_MATCH, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE));
        send_item(make_item(CMD_MATCH, 8'h00, rnd_byte(), rnd_byte(),
                            rnd_byte(), rnd_byte()));
    endtask

    // Largest distances: white entry against a black pixel, and the reverse
    task automatic test_extreme_distance();
        wait_drained();
        set_config(1'b1, 8'd255, 8'd255, 1'b0, 24'h000000);
        send_item(make_item(CMD_MATCH, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_drained();
        set_config(1'b0, 8'd0, 8'd0, 1'b0, 24'h000000);
        send_item(make_item(CMD_MATCH, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Identical entries across the range: the lowest index must win
    task automatic test_ties();
        ncs_rgba_t c;
        wait_drained();
        set_config(1'b0, 8'd40, 8'd47, 1'b0, 24'h000000);
        c = $urandom();
        for (int i = 40; i <= 47; i++)
            send_item(make_item(CMD_LOAD, i[INDEX_W-1:0], c.red, c.green, c.blue, c.alpha));
        send_item(make_item(CMD_MATCH, 8'd0, c.red, c.green, c.blue, c.alpha));
        send_item(make_item(CMD_MATCH, 8'd0, ~c.red, c.green, ~c.blue, c.alpha));
    endtask

    // First beyond last: only range_first is reported
    task automatic test_inverted_range();
        wait_drained();
        set_config(1'b0, 8'd200, 8'd100, 1'b0, 24'h000000);
        send_item(make_item(CMD_MATCH, 8'd0, rnd_byte(), rnd_byte(),
                            rnd_byte(), rnd_byte()));
        wait_drained();
        set_config(1'b1, 8'd255, 8'd0, 1'b0, 24'h000000);
        send_item(make_item(CMD_MATCH, 8'd0, 8'h12, 8'h34, 8'h56, 8'h78));
    endtask

    // Key colour: hit ignores alpha, near miss scans, disabled key never hits
    task automatic test_key_colour();
        logic [KEY_W-1:0] k;
        wait_drained();
        set_config(1'b0, 8'd0, 8'd15, 1'b1, 24'hFFFFFF);
        send_item(make_item(CMD_MATCH, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'h05));
        send_item(make_item(CMD_MATCH, 8'd0, 8'hFF, 8'hFF, 8'hFE, 8'h00));
        wait_drained();
        set_config(1'b1, 8'd3, 8'd9, 1'b1, 24'h000000);
        send_item(make_item(CMD_MATCH, 8'd0, 8'h00, 8'h00, 8'h00, 8'hFF));
        wait_drained();
        k = KEY_W'($urandom());
        set_config(1'b0, 8'd0, 8'd7, 1'b0, k);
        send_item(make_item(CMD_MATCH, 8'd0, k[23:16], k[15:8], k[7:0], 8'h00));
    endtask

    // One random phase: fresh settings, then a mix of loads and matches
    task automatic run_random_phase(input int n_items);
        logic [INDEX_W-1:0] f;
        logic [INDEX_W-1:0] l;
        logic [INDEX_W-1:0] lo;
        logic [INDEX_W-1:0] hi;
        logic [KEY_W-1:0]   k;
        ncs_rgba_t          c;
        ncs_in_t            it;
        int                 pick;
        int                 w;
        wait_drained();
        pick = $urandom_range(99, 0);
        f    = rnd_index(255, 0);
        if (pick < 8)
        begin
            f = 8'd0;
            l = 8'd255;
        end
        else if (pick < 20)
        begin
            l = rnd_index(254, 0);
            f = rnd_index(255, int'(l) + 1);
        end
        else
        begin
            w = $urandom_range(12, 0);
            l = (int'(f) + w > 255) ? 8'd255 : f + w[INDEX_W-1:0];
        end
        c = palette_shadow[rnd_index(255, 0)];
        k = ($urandom_range(1, 0) != 0) ? {c.red, c.green, c.blue} : KEY_W'($urandom());
        set_config(1'($urandom_range(1, 0)), f, l, 1'($urandom_range(1, 0)), k);
        lo = (f < l) ? f : l;
        hi = (f < l) ? l : f;
        repeat (n_items)
        begin
            pick = $urandom_range(99, 0);
            it   = make_item(CMD_MATCH, rnd_index(255, 0), rnd_byte(),
                             rnd_byte(), rnd_byte(), rnd_byte());
            if (pick < 30)
            begin
                it.cmd = CMD_LOAD;
                if (pick < 15)
                    it.entry_index = rnd_index(int'(hi), int'(lo));
            end
            else if (pick < 45)
                {it.red, it.green, it.blue} = key_rgb;
            else if (pick < 75)
            begin
                // Pixel close to an entry inside the scanned range
                c        = palette_shadow[rnd_index(int'(hi), int'(lo))];
                it.red   = c.red ^ COLOR_W'($urandom_range(3, 0));
                it.green = c.green ^ COLOR_W'($urandom_range(3, 0));
                it.blue  = c.blue ^ COLOR_W'($urandom_range(3, 0));
                it.alpha = c.alpha ^ COLOR_W'($urandom_range(3, 0));
            end
            send_item(it);
        end
    endtask

    task automatic test_random(input int idle_pct);
        send_idle_pct = idle_pct;
        repeat (6) run_random_phase(12);
    endtask

    // Main sequence
    initial
    begin
        int guard;
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        item          = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        err_count     = 0;
        send_idle_pct = 15;
        mode_weighted = 1'b0;
        scan_first    = 8'd0;
        scan_last     = 8'd255;
        key_en        = 1'b0;
        key_rgb       = '0;
        foreach (palette_shadow[i])
            palette_shadow[i] = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_palette_fill();
        test_full_range();
        test_extreme_distance();
        test_ties();
        test_inverted_range();
        test_key_colour();
        test_random(15);
        test_random(78);
        test_random(0);

        // Drain with a bound, then let the pipeline settle
        start = 1'b0;
        guard = 0;
        while (pending_matches.size() != 0 && guard < 2000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);
        if (pending_matches.size() != 0)
        begin
            err_count++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, pending_matches.size());
        end
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== nearest_palette_color_search.f =====
hw/rtl/npcs_pkg.sv
hw/rtl/npcs_ram.sv
hw/rtl/npcs_dist.sv
hw/rtl/nearest_palette_color_search.sv
dv/tb_top.sv
